@@ rtl/core/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter package
// Shared widths, types and helper functions of the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  // Width of the value port and of the value bits that take part.
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IN_VALUE_W  = 32;
  localparam int unsigned EFF_W       = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;

  // Field widths of the ports.
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned COUNT_W = 6;

  // Radix limits.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  // Divider: quotient bits resolved per cycle and division steps per digit.
  localparam int unsigned DIV_BITS = 8;
  localparam int unsigned STEPS    = (EFF_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned WORK_W   = STEPS * DIV_BITS;
  localparam int unsigned STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Digit store sizing.
  localparam int unsigned CNT_W = $clog2(EFF_W + 1);
  localparam int unsigned IDX_W = $clog2(EFF_W);

  // ASCII offsets for digits and letters.
  localparam logic [CHAR_W-1:0] ASCII_ZERO        = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] ASCII_LETTER_BIAS = CHAR_W'(8'h37);
  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS   = RADIX_W'(10);

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic [EFF_W-1:0]   value;
    logic [RADIX_W-1:0] radix;
    logic               radix_err;
  } rdc_cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } rdc_state_e;

  // Map a remainder to its ASCII digit.
  function automatic logic [CHAR_W-1:0] rdc_digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_DIGITS) begin
      c = CHAR_W'(d) + ASCII_ZERO;
    end else begin
      c = CHAR_W'(d) + ASCII_LETTER_BIAS;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/radix_digit_converter_top.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts an unsigned value to ASCII digits in a radix from 2 to 36.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Fields
//  request   push / full        value_i[31:0], radix_i[5:0]
//  result    empty / pop        digit_char_o[6:0], digit_count_o[5:0],
//                               last_digit_o, radix_error_o
//
// The divider in the digit engine resolves eight quotient bits per cycle, so
// each digit costs four division steps, and the stacked digits then leave
// one per cycle unless the result stalls. A bad radix gives one error result.
// A two-entry queue holds waiting requests; result stalls hold the output
// register and stop the emission. Reset clears queue and engine.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_top
  import rdc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [IN_VALUE_W-1:0] value_i,
  input  wire logic [RADIX_W-1:0]    radix_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [CHAR_W-1:0]          digit_char_o,
  output logic [COUNT_W-1:0]         digit_count_o,
  output logic                       last_digit_o,
  output logic                       radix_error_o
);

  rdc_cmd_t front_cmd;
  rdc_cmd_t q_cmd;
  logic     q_valid;
  logic     q_pop;

  // Request classification.
  rdc_front u_front (
    .value_i (value_i),
    .radix_i (radix_i),
    .cmd_o   (front_cmd)
  );

  // Decoupling queue.
  rdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  // Digit engine and result register.
  rdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .digit_char_o  (digit_char_o),
    .digit_count_o (digit_count_o),
    .last_digit_o  (last_digit_o),
    .radix_error_o (radix_error_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/rdc_front.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter front end
// Trims the incoming value and checks the radix of each request.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_front
  import rdc_pkg::*;
(
  input  wire logic [IN_VALUE_W-1:0] value_i,
  input  wire logic [RADIX_W-1:0]    radix_i,
  output rdc_cmd_t                   cmd_o
);

  // Only the low value bits take part; a radix outside the legal range is flagged.
  always_comb begin
    cmd_o.value     = value_i[EFF_W-1:0];
    cmd_o.radix     = radix_i;
    cmd_o.radix_err = !(radix_i inside {[RADIX_MIN:RADIX_MAX]});
  end

endmodule

`default_nettype wire

@@ rtl/core/rdc_queue.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter request queue
// Two-entry queue that decouples the front end from the digit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_queue
  import rdc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  rdc_cmd_t  cmd_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output rdc_cmd_t  cmd_o
);

  rdc_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rdc_back.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter back end
// Divides by the radix a byte of quotient per cycle, stacks the remainders
// and emits them most significant first through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_back
  import rdc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  rdc_cmd_t                 q_cmd_i,
  output logic                     q_pop_o,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output logic [CHAR_W-1:0]        digit_char_o,
  output logic [COUNT_W-1:0]       digit_count_o,
  output logic                     last_digit_o,
  output logic                     radix_error_o
);

  rdc_state_e          state_q, state_d;
  logic [WORK_W-1:0]   val_q, val_d;
  logic [RADIX_W-1:0]  radix_q, radix_d;
  logic                err_q, err_d;
  logic [RADIX_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [RADIX_W-1:0]  stack_q [EFF_W];

  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic [COUNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic                out_last_q, out_last_d;
  logic                out_err_q, out_err_d;

  logic [RADIX_W-1:0]  rem_next;
  logic [DIV_BITS-1:0] qbits;
  logic [WORK_W-1:0]   quot_next;
  logic                last_step;
  logic                quot_zero;
  logic                load_out;
  logic                stack_we;
  logic [CNT_W-1:0]    ptr_m1;
  logic [IDX_W-1:0]    rd_idx;

  // Restoring division over the top byte of the working value.
  always_comb begin
    logic [DIV_BITS-1:0] top;
    logic [RADIX_W:0]    t;
    logic [RADIX_W-1:0]  r;
    top   = val_q[WORK_W-1 -: DIV_BITS];
    r     = rem_q;
    qbits = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      t = {r, top[i]};
      if (t >= {1'b0, radix_q}) begin
        qbits[i] = 1'b1;
        t        = t - {1'b0, radix_q};
      end
      r = t[RADIX_W-1:0];
    end
    rem_next  = r;
    quot_next = (val_q << DIV_BITS) | WORK_W'(qbits);
  end

  assign last_step = (step_q == STEP_W'(STEPS - 1));
  assign quot_zero = (quot_next == '0);
  assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || pop_i);
  assign ptr_m1    = ptr_q - CNT_W'(1);
  assign rd_idx    = ptr_m1[IDX_W-1:0];
  assign stack_we  = (state_q == ST_DIVIDE) && last_step;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = q_cmd_i.radix_err ? ST_EMIT : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (last_step && quot_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out && (ptr_q == CNT_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and output register control.
  always_comb begin
    q_pop_o     = 1'b0;
    val_d       = val_q;
    radix_d     = radix_q;
    err_d       = err_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;

    if (pop_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        val_d   = WORK_W'(q_cmd_i.value);
        radix_d = q_cmd_i.radix;
        err_d   = q_cmd_i.radix_err;
        rem_d   = '0;
        step_d  = '0;
        cnt_d   = '0;
        ptr_d   = CNT_W'(1);
      end
      ST_DIVIDE: begin
        val_d = quot_next;
        if (last_step) begin
          rem_d  = '0;
          step_d = '0;
          cnt_d  = cnt_q + CNT_W'(1);
          ptr_d  = cnt_q + CNT_W'(1);
        end else begin
          rem_d  = rem_next;
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          ptr_d       = ptr_m1;
          if (err_q) begin
            out_char_d = '0;
            out_cnt_d  = '0;
            out_last_d = 1'b0;
            out_err_d  = 1'b1;
          end else begin
            out_char_d = rdc_digit_char(stack_q[rd_idx]);
            out_cnt_d  = COUNT_W'(cnt_q);
            out_last_d = (ptr_q == CNT_W'(1));
            out_err_d  = 1'b0;
          end
        end
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    radix_q    <= radix_d;
    err_q      <= err_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
    if (stack_we) begin
      stack_q[cnt_q[IDX_W-1:0]] <= rem_next;
    end
  end

  assign empty_o       = !out_valid_q;
  assign digit_char_o  = out_char_q;
  assign digit_count_o = out_cnt_q;
  assign last_digit_o  = out_last_q;
  assign radix_error_o = out_err_q;

endmodule

`default_nettype wire

@@ rtl/core/rdc_checker.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter checker
// Port-level assertions on the result stream of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker
  import rdc_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire logic [CHAR_W-1:0]     digit_char_o,
  input wire logic [COUNT_W-1:0]    digit_count_o,
  input wire logic                  last_digit_o,
  input wire logic                  radix_error_o
);

  // An error result carries no digit, count or last flag.
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && radix_error_o) |->
      (digit_char_o == '0) && (digit_count_o == '0) && !last_digit_o)
    else $error("error result carries digit fields");

  // A digit result has a legal count and an ASCII digit or capital letter.
  a_digit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !radix_error_o) |->
      (digit_count_o != '0) && (digit_count_o <= COUNT_W'(EFF_W)) &&
      (((digit_char_o >= CHAR_W'(8'h30)) && (digit_char_o <= CHAR_W'(8'h39))) ||
       ((digit_char_o >= CHAR_W'(8'h41)) && (digit_char_o <= CHAR_W'(8'h5A)))))
    else $error("digit result out of range");

  // Within one conversion the next digit follows at once with the same count.
  a_digit_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !radix_error_o && !last_digit_o) |=>
      !empty && !radix_error_o && (digit_count_o == $past(digit_count_o)))
    else $error("digit run broken");

  // A result that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      !empty && $stable(digit_char_o) && $stable(digit_count_o) &&
      $stable(last_digit_o) && $stable(radix_error_o))
    else $error("stalled result changed");

endmodule

bind radix_digit_converter_top rdc_checker u_rdc_checker (.*);

`default_nettype wire
